// ===== rtl/core/transport_receiver_ack_pull_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pull-based transport receiver
// Shared concurrent assertion forms; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_RECEIVER_ACK_PULL_MACROS_SVH
`define TRANSPORT_RECEIVER_ACK_PULL_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define TRAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TRAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TRAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/trap_pkg.sv =====
// ----------------------------------------------------------------------------
// trap_pkg
// Types and constants shared by the transport receiver modules.
// ----------------------------------------------------------------------------
package trap_pkg;

    localparam int WINDOW_SEGMENTS = 64;
    localparam int WIN_IDX_W       = $clog2(WINDOW_SEGMENTS);
    localparam int SEQ_W           = 32;
    localparam int SEG_W           = 14;
    localparam int DIV_CNT_W       = $clog2(SEQ_W);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BYTES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 1'b1;

    localparam logic [SEG_W-1:0] SEGMENT_BYTES_RESET = 14'd1460;

    localparam logic REPLY_ACK  = 1'b0;
    localparam logic REPLY_NACK = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic             trimmed_header;
        logic             last_segment;
    } pkt_t;

    typedef struct packed {
        logic             reply_kind;
        logic [SEQ_W-1:0] echo_seq;
        logic [SEQ_W-1:0] cumulative_ack;
        logic             nack_wants_pull;
        logic             pull_valid;
        logic [SEQ_W-1:0] pull_number;
        logic             pull_flush;
        logic             flow_complete;
        logic             stale_retransmit;
        logic             window_overflow;
    } reply_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic classify;
        logic pop;
        logic div_step;
        logic mark;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trimmed;
        logic seq_eq;
        logic seq_lt;
        logic pop_bit;
        logic div_last;
    } dp_status_t;

endpackage

// ===== rtl/core/transport_receiver_ack_pull.sv =====
// From packet acceptance to reply valid: a trimmed or stale packet goes from classify to finish,
// an in-order packet pops the window (one window pop per cycle) until a pop finds a gap, and a
// later packet runs a 32-step restoring divider on the offset, then marks the window.
// One packet at a time: the next packet is taken in the cycle after the reply register
// is loaded, and a waiting reply stalls only that load.
// Reset clears the cumulative ack, window and pull counter and reloads the register defaults.
// ----------------------------------------------------------------------------
// transport_receiver_ack_pull
// Receiver side of a pull-based transport: per-packet ACK or NACK with a
// cumulative ack, out-of-order segment window and pull issue.
// ----------------------------------------------------------------------------
`include "transport_receiver_ack_pull_macros.svh"

module transport_receiver_ack_pull (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pkt_valid,
    output logic                              pkt_ready,
    input  trap_pkg::pkt_t                    pkt,
    output logic                              reply_valid,
    input  logic                              reply_ready,
    output trap_pkg::reply_t                  reply,
    input  logic                              cfg_write,
    input  logic [trap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trap_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import trap_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    trap_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .status      (status),
        .cmd         (cmd)
    );

    trap_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .reply     (reply)
    );

    `TRAP_ASSERT_IMP(a_nack_flags, clk, rst_n, reply_valid && reply.reply_kind == REPLY_NACK,
        !reply.stale_retransmit && !reply.window_overflow, "NACK with ack-only flags")
    `TRAP_ASSERT_IMP(a_ack_no_pull_req, clk, rst_n, reply_valid && reply.reply_kind == REPLY_ACK,
        !reply.nack_wants_pull, "ACK requests resend")
    `TRAP_ASSERT_IMP(a_complete_flush, clk, rst_n, reply_valid && reply.flow_complete,
        reply.pull_flush, "complete flow without flush")

endmodule

// ===== rtl/core/trap_dp.sv =====
// ----------------------------------------------------------------------------
// trap_dp
// Datapath: sequence state, held-segment window, divider, pull counter,
// configuration registers and the reply register.
// ----------------------------------------------------------------------------
`include "transport_receiver_ack_pull_macros.svh"

module trap_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  trap_pkg::pkt_t                     pkt,
    input  logic                               cfg_write,
    input  logic [trap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trap_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  trap_pkg::dp_cmd_t                  cmd,
    output trap_pkg::dp_status_t               status,
    output trap_pkg::reply_t                   reply
);
    import trap_pkg::*;

    logic [SEQ_W-1:0]           flow_bytes_reg, flow_bytes_next;
    logic [SEG_W-1:0]           seg_bytes_reg, seg_bytes_next;
    logic [SEQ_W-1:0]           next_expected_reg, next_expected_next;
    logic [WINDOW_SEGMENTS-1:0] window_reg, window_next;
    logic [SEQ_W-1:0]           pull_counter_reg, pull_counter_next;

    logic [SEQ_W-1:0]           seq_reg, seq_next;
    logic                       trimmed_reg, trimmed_next;
    logic                       last_reg, last_next;
    logic                       stale_reg, stale_next;
    logic                       overflow_reg, overflow_next;

    logic [SEQ_W-1:0]           quo_reg, quo_next;
    logic [SEG_W-1:0]           rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;

    reply_t                     reply_reg, reply_next;

    logic [SEG_W-1:0]           step;
    logic [SEQ_W-1:0]           step_ext;
    logic [SEG_W:0]             rem_shift;
    logic [SEG_W:0]             rem_diff;
    logic                       rem_fits;
    logic [SEQ_W-1:0]           quo_minus;
    logic [WIN_IDX_W-1:0]       mark_idx;
    logic [WINDOW_SEGMENTS-1:0] mark_mask;
    logic                       mark_aligned;
    logic                       mark_overflow;
    logic                       complete;

    // A segment size of zero behaves as one byte.
    assign step     = (seg_bytes_reg == '0) ? SEG_W'(1) : seg_bytes_reg;
    assign step_ext = {{(SEQ_W-SEG_W){1'b0}}, step};

    // One restoring division step per cycle.
    assign rem_shift = {rem_reg, quo_reg[SEQ_W-1]};
    assign rem_diff  = rem_shift - {1'b0, step};
    assign rem_fits  = rem_shift >= {1'b0, step};

    assign mark_aligned  = (rem_reg == '0);
    assign mark_overflow = mark_aligned && (quo_reg > SEQ_W'(WINDOW_SEGMENTS));
    assign quo_minus     = quo_reg - SEQ_W'(1);
    assign mark_idx      = quo_minus[WIN_IDX_W-1:0];
    assign mark_mask     = {{(WINDOW_SEGMENTS-1){1'b0}}, 1'b1} << mark_idx;

    assign complete = next_expected_reg >= flow_bytes_reg;

    assign status.trimmed  = trimmed_reg;
    assign status.seq_eq   = (seq_reg == next_expected_reg);
    assign status.seq_lt   = (seq_reg < next_expected_reg);
    assign status.pop_bit  = window_reg[0];
    assign status.div_last = (div_cnt_reg == '1);

    assign reply = reply_reg;

    always_comb
    begin
        flow_bytes_next    = flow_bytes_reg;
        seg_bytes_next     = seg_bytes_reg;
        next_expected_next = next_expected_reg;
        window_next        = window_reg;
        pull_counter_next  = pull_counter_reg;
        seq_next           = seq_reg;
        trimmed_next       = trimmed_reg;
        last_next          = last_reg;
        stale_next         = stale_reg;
        overflow_next      = overflow_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        div_cnt_next       = div_cnt_reg;
        reply_next         = reply_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FLOW_BYTES:    flow_bytes_next = cfg_data[SEQ_W-1:0];
                CFG_SEGMENT_BYTES: seg_bytes_next  = cfg_data[SEG_W-1:0];
                default:           ;
            endcase
        end

        if (cmd.capture)
        begin
            seq_next      = pkt.seq_number;
            trimmed_next  = pkt.trimmed_header;
            last_next     = pkt.last_segment;
            stale_next    = 1'b0;
            overflow_next = 1'b0;
        end

        if (cmd.classify && !trimmed_reg)
        begin
            if (status.seq_eq)
            begin
                next_expected_next = next_expected_reg + step_ext;
            end
            else if (status.seq_lt)
            begin
                stale_next = 1'b1;
            end
            else
            begin
                quo_next     = seq_reg - next_expected_reg;
                rem_next     = '0;
                div_cnt_next = '0;
            end
        end

        // Every pop shifts the window; a set bit also moves the ack on by one segment.
        if (cmd.pop)
        begin
            window_next = window_reg >> 1;
            if (window_reg[0])
            begin
                next_expected_next = next_expected_reg + step_ext;
            end
        end

        if (cmd.div_step)
        begin
            rem_next     = rem_fits ? rem_diff[SEG_W-1:0] : rem_shift[SEG_W-1:0];
            quo_next     = {quo_reg[SEQ_W-2:0], rem_fits};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.mark && mark_aligned)
        begin
            if (mark_overflow)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                window_next = window_reg | mark_mask;
            end
        end

        if (cmd.finish)
        begin
            reply_next.reply_kind       = trimmed_reg ? REPLY_NACK : REPLY_ACK;
            reply_next.echo_seq         = seq_reg;
            reply_next.cumulative_ack   = next_expected_reg;
            reply_next.nack_wants_pull  = trimmed_reg & last_reg;
            reply_next.flow_complete    = complete;
            reply_next.stale_retransmit = stale_reg;
            reply_next.window_overflow  = overflow_reg;
            if (complete || last_reg)
            begin
                reply_next.pull_valid  = 1'b0;
                reply_next.pull_number = '0;
                reply_next.pull_flush  = 1'b1;
            end
            else
            begin
                pull_counter_next      = pull_counter_reg + SEQ_W'(1);
                reply_next.pull_valid  = 1'b1;
                reply_next.pull_number = pull_counter_reg + SEQ_W'(1);
                reply_next.pull_flush  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_bytes_reg    <= '0;
            seg_bytes_reg     <= SEGMENT_BYTES_RESET;
            next_expected_reg <= '0;
            window_reg        <= '0;
            pull_counter_reg  <= '0;
        end
        else
        begin
            flow_bytes_reg    <= flow_bytes_next;
            seg_bytes_reg     <= seg_bytes_next;
            next_expected_reg <= next_expected_next;
            window_reg        <= window_next;
            pull_counter_reg  <= pull_counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        trimmed_reg  <= trimmed_next;
        last_reg     <= last_next;
        stale_reg    <= stale_next;
        overflow_reg <= overflow_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        reply_reg    <= reply_next;
    end

    `TRAP_ASSERT_NXT(a_pull_exclusive, clk, rst_n, cmd.finish,
        reply_reg.pull_valid != reply_reg.pull_flush, "pull and flush both or neither set")
    `TRAP_ASSERT_NXT(a_pop_advance, clk, rst_n, cmd.pop && window_reg[0],
        next_expected_reg == $past(next_expected_reg + step_ext), "pop did not advance ack")
    `TRAP_ASSERT_NXT(a_overflow_no_mark, clk, rst_n, cmd.mark && mark_overflow,
        $stable(window_reg), "window changed on overflow")

endmodule

// ===== rtl/core/trap_ctrl.sv =====
// ----------------------------------------------------------------------------
// trap_ctrl
// Controller: sequences one packet through classify, window pop or
// division and marking if not stale or trimmed, then loads the reply register.
// ----------------------------------------------------------------------------
`include "transport_receiver_ack_pull_macros.svh"

module trap_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_ready,
    output logic                 reply_valid,
    input  logic                 reply_ready,
    input  trap_pkg::dp_status_t status,
    output trap_pkg::dp_cmd_t    cmd
);
    import trap_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLASSIFY = 6'b000010,
        S_POP      = 6'b000100,
        S_DIVIDE   = 6'b001000,
        S_MARK     = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   reply_valid_reg, reply_valid_next;
    logic   out_free;

    assign pkt_ready   = (state_reg == S_IDLE);
    assign reply_valid = reply_valid_reg;
    assign out_free    = !reply_valid_reg || reply_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                if (status.trimmed || status.seq_lt)
                begin
                    state_next = S_FINISH;
                end
                else if (status.seq_eq)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (!status.pop_bit)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        reply_valid_next = reply_valid_reg;
        if (cmd.finish)
        begin
            reply_valid_next = 1'b1;
        end
        else if (reply_ready)
        begin
            reply_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    `TRAP_ASSERT_NXT(a_accept_classify, clk, rst_n, pkt_valid && pkt_ready,
        state_reg == S_CLASSIFY, "accepted packet not classified")
    `TRAP_ASSERT_NXT(a_finish_loads, clk, rst_n, cmd.finish,
        reply_valid_reg && state_reg == S_IDLE, "finish did not load reply")
    `TRAP_ASSERT_NXT(a_div_done, clk, rst_n, state_reg == S_DIVIDE && status.div_last,
        state_reg == S_MARK, "divider end not followed by mark")
    `TRAP_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE,
        !pkt_ready, "ready while a packet is in progress")

endmodule

// ===== tb/tb_transport_receiver_ack_pull_check.sv =====
// ----------------------------------------------------------------------------
// tb_transport_receiver_ack_pull_check
// Watches the packet, reply and register ports of the transport receiver,
// computes the reply owed for every packet transfer and compares each reply
// transfer, field by field, with the oldest reply still owed.
// ----------------------------------------------------------------------------
module tb_transport_receiver_ack_pull_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pkt_valid,
    input  logic                            pkt_ready,
    input  trap_pkg::pkt_t                  pkt,
    input  logic                            reply_valid,
    input  logic                            reply_ready,
    input  trap_pkg::reply_t                reply,
    input  logic                            cfg_write,
    input  logic [trap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trap_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [trap_pkg::SEQ_W-1:0]      cum_ack,
    output int                              pending,
    output int                              fail_count
);
    import trap_pkg::*;

    localparam int PRINT_LIMIT = 40;

    logic [SEQ_W-1:0]           flow_size    = '0;
    logic [SEG_W-1:0]           seg_size     = SEGMENT_BYTES_RESET;
    logic [SEQ_W-1:0]           next_byte    = '0;
    logic [WINDOW_SEGMENTS-1:0] held_map     = '0;
    logic [SEQ_W-1:0]           pulls_issued = '0;
    reply_t                     owed_replies[$];
    int                         owed_count   = 0;
    int                         mismatches   = 0;

    assign cum_ack    = next_byte;
    assign pending    = owed_count;
    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] reply mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(input string field, input logic [SEQ_W-1:0] got,
                               input logic [SEQ_W-1:0] want, input logic [SEQ_W-1:0] seq);
        if (got !== want)
            report_mismatch($sformatf("seq %h: %s is %h, expected %h", seq, field, got, want));
    endtask

    task automatic compare_reply(input reply_t got, input reply_t want);
        check_field("reply_kind", SEQ_W'(got.reply_kind), SEQ_W'(want.reply_kind),
                    want.echo_seq);
        check_field("echo_seq", got.echo_seq, want.echo_seq, want.echo_seq);
        check_field("cumulative_ack", got.cumulative_ack, want.cumulative_ack, want.echo_seq);
        check_field("nack_wants_pull", SEQ_W'(got.nack_wants_pull),
                    SEQ_W'(want.nack_wants_pull), want.echo_seq);
        check_field("pull_valid", SEQ_W'(got.pull_valid), SEQ_W'(want.pull_valid),
                    want.echo_seq);
        check_field("pull_number", got.pull_number, want.pull_number, want.echo_seq);
        check_field("pull_flush", SEQ_W'(got.pull_flush), SEQ_W'(want.pull_flush),
                    want.echo_seq);
        check_field("flow_complete", SEQ_W'(got.flow_complete), SEQ_W'(want.flow_complete),
                    want.echo_seq);
        check_field("stale_retransmit", SEQ_W'(got.stale_retransmit),
                    SEQ_W'(want.stale_retransmit), want.echo_seq);
        check_field("window_overflow", SEQ_W'(got.window_overflow),
                    SEQ_W'(want.window_overflow), want.echo_seq);
    endtask

    // Advances the receiver state by one packet and builds the reply it owes.
    task automatic ack_packet(input pkt_t p, output reply_t r);
        logic [SEQ_W-1:0] step;
        logic [SEQ_W-1:0] delta;
        logic [SEQ_W-1:0] slot;
        logic             popped;
        int               n;
        r = '0;
        step = (seg_size == '0) ? 32'd1 : 32'(seg_size);
        r.reply_kind = REPLY_ACK;
        r.echo_seq = p.seq_number;
        if (p.trimmed_header) begin
            r.reply_kind = REPLY_NACK;
            r.nack_wants_pull = p.last_segment;
        end
        else if (p.seq_number == next_byte) begin
            // Step over the new segment, then over every held segment right behind it.
            // The window shifts on each pop, including the one that finds a gap.
            next_byte = next_byte + step;
            for (n = 0; n <= WINDOW_SEGMENTS; n++) begin
                popped = held_map[0];
                held_map = held_map >> 1;
                if (!popped)
                    break;
                next_byte = next_byte + step;
            end
        end
        else if (p.seq_number < next_byte) begin
            r.stale_retransmit = 1'b1;
        end
        else begin
            delta = p.seq_number - next_byte;
            // An offset that is not a whole number of segments is acked and dropped.
            if (delta % step == '0) begin
                slot = delta / step - 32'd1;
                if (slot >= WINDOW_SEGMENTS)
                    r.window_overflow = 1'b1;
                else
                    held_map[slot[WIN_IDX_W-1:0]] = 1'b1;
            end
        end
        r.cumulative_ack = next_byte;
        r.flow_complete = (next_byte >= flow_size);
        if (r.flow_complete || p.last_segment) begin
            r.pull_flush = 1'b1;
        end
        else begin
            pulls_issued = pulls_issued + 32'd1;
            r.pull_valid = 1'b1;
            r.pull_number = pulls_issued;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        if (!rst_n) begin
            flow_size = '0;
            seg_size = SEGMENT_BYTES_RESET;
            next_byte = '0;
            held_map = '0;
            pulls_issued = '0;
            owed_replies.delete();
        end
        else begin
            if (reply_valid && reply_ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch($sformatf("reply for seq %h with none outstanding",
                                              reply.echo_seq));
                end
                else begin
                    want = owed_replies.pop_front();
                    compare_reply(reply, want);
                end
            end
            if (pkt_valid && pkt_ready) begin
                ack_packet(pkt, want);
                owed_replies.insert(owed_replies.size(), want);
            end
            if (cfg_write) begin
                if (cfg_index == CFG_FLOW_BYTES)
                    flow_size = cfg_data[SEQ_W-1:0];
                else if (cfg_index == CFG_SEGMENT_BYTES)
                    seg_size = cfg_data[SEG_W-1:0];
            end
        end
        owed_count = owed_replies.size();
    end

endmodule

// ===== tb/tb_transport_receiver_ack_pull.sv =====
// ----------------------------------------------------------------------------
// tb_transport_receiver_ack_pull
// Drives packets and register writes into the transport receiver and stalls
// its reply port; a checker beside the block predicts and compares replies.
// A directed part covers the corner cases, then random phases run with
// different segment sizes, flow sizes and idle patterns on both ports.
// ----------------------------------------------------------------------------
module tb_transport_receiver_ack_pull;
    import trap_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 330;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  pkt_valid   = 1'b0;
    pkt_t                  pkt         = '0;
    logic                  reply_ready = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  pkt_ready;
    logic                  reply_valid;
    reply_t                reply;
    logic [SEQ_W-1:0]      cum_ack;
    int                    pending;
    int                    fail_count;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_asked    = 0;
    int               hold_taken    = 0;
    int               hold_left     = 0;
    int               cycles        = 0;
    logic [SEQ_W-1:0] step_now      = 32'd1460;

    transport_receiver_ack_pull DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .pkt         (pkt),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tb_transport_receiver_ack_pull_check reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .pkt         (pkt),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cum_ack     (cum_ack),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reply side: random stalls, or a long hold-off when one is asked for.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            reply_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_taken) begin
            hold_taken <= hold_asked;
            hold_left <= HOLD_CYCLES;
            reply_ready <= 1'b0;
        end
        else begin
            reply_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both registers are written back to back, with the write enable held high.
    task automatic write_config(input logic [SEQ_W-1:0] flow, input logic [SEG_W-1:0] seg);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FLOW_BYTES;
        cfg_data <= flow;
        @(negedge clk);
        cfg_index <= CFG_SEGMENT_BYTES;
        cfg_data <= CFG_DATA_W'(seg);
        @(negedge clk);
        cfg_write <= 1'b0;
        step_now = (seg == '0) ? 32'd1 : 32'(seg);
    endtask

    task automatic send_pkt(input pkt_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_valid <= 1'b0;
            @(negedge clk);
        end
        pkt_valid <= 1'b1;
        pkt <= p;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering packets until every owed reply has been transferred.
    task automatic drain();
        pkt_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // A packet placed k segments away from the current cumulative ack.
    function automatic pkt_t seg_pkt(input int k, input logic [SEQ_W-1:0] extra,
                                     input logic trim, input logic last);
        pkt_t p;
        p.seq_number = cum_ack + 32'(k) * step_now + extra;
        p.trimmed_header = trim;
        p.last_segment = last;
        return p;
    endfunction

    function automatic pkt_t raw_pkt(input logic [SEQ_W-1:0] seq, input logic trim,
                                     input logic last);
        pkt_t p;
        p.seq_number = seq;
        p.trimmed_header = trim;
        p.last_segment = last;
        return p;
    endfunction

    // Mostly a plausible sender: in-order data, reordering within the window,
    // retransmits and trims, with some packets around the window edge and noise.
    function automatic pkt_t random_pkt();
        int   pick;
        logic last;
        pkt_t p;
        pick = $urandom_range(99);
        last = ($urandom_range(9) == 0);
        if (pick < 30)
            p = seg_pkt(0, '0, 1'b0, last);
        else if (pick < 56)
            p = seg_pkt($urandom_range(12, 1), '0, 1'b0, last);
        else if (pick < 64)
            p = seg_pkt(-int'($urandom_range(4, 1)), '0, 1'b0, last);
        else if (pick < 70)
            p = seg_pkt($urandom_range(67, 62), '0, 1'b0, last);
        else if (pick < 76 && step_now > 1)
            p = seg_pkt($urandom_range(8, 1), $urandom_range(step_now - 1, 1), 1'b0, last);
        else if (pick < 90)
            p = seg_pkt($urandom_range(4, 0), '0, 1'b1, last);
        else
            p = raw_pkt($urandom(), 1'($urandom_range(1)), last);
        return p;
    endfunction

    task automatic stream(input int count, input int s_idle, input int r_idle,
                          input int hold_at, input int pause_at);
        int i;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_asked = hold_asked + 1;
            if (i == pause_at)
                drain();
            send_pkt(random_pkt());
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_config(20 * 1460, 14'd1460);
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(2, '0, 1'b1, 1'b0));
        send_pkt(seg_pkt(2, '0, 1'b1, 1'b1));
        send_pkt(seg_pkt(2, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(2, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(1, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(3, 32'd100, 1'b0, 1'b0));
        send_pkt(seg_pkt(64, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(65, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(-2, '0, 1'b0, 1'b0));
        send_pkt(raw_pkt(32'hFFFF_FFFF, 1'b0, 1'b0));
        send_pkt(raw_pkt(32'h0, 1'b1, 1'b1));
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b1));
        repeat (4) send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));

        // A zero segment size steps the cumulative ack by one byte.
        drain();
        write_config(32'd0, 14'd0);
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(1, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));
        send_pkt(raw_pkt(32'h0, 1'b0, 1'b0));

        drain();
        write_config(32'hFFFF_FFFF, 14'd9000);
        send_pkt(seg_pkt(0, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(65, '0, 1'b0, 1'b0));
        send_pkt(seg_pkt(1, 32'd1, 1'b0, 1'b0));

        drain();
        write_config(cum_ack + 50 * 1460, 14'd1460);
        stream(PHASE_ITEMS, 21, 48, -1, -1);
        drain();
        write_config(32'hFFFF_FFFF, 14'd9000);
        stream(PHASE_ITEMS, 21, 48, 60, -1);
        drain();
        write_config(cum_ack + 100, 14'd1);
        stream(PHASE_ITEMS, 48, 21, -1, -1);
        drain();
        write_config(32'd0, 14'd0);
        stream(PHASE_ITEMS, 48, 21, -1, 150);
        drain();
        write_config(cum_ack + 200 * 512, 14'd512);
        stream(PHASE_ITEMS, 0, 0, 100, -1);
        drain();
        write_config(cum_ack + 30 * 9000, 14'd9000);
        stream(PHASE_ITEMS, 0, 0, -1, -1);
        drain();
        repeat (64) @(negedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/trap_pkg.sv
rtl/core/trap_dp.sv
rtl/core/trap_ctrl.sv
rtl/core/transport_receiver_ack_pull.sv
tb/tb_transport_receiver_ack_pull_check.sv
tb/tb_transport_receiver_ack_pull.sv
